// ===== rtl/core/bsl_pkg.sv =====
package bsl_pkg;

  // Command codes carried by an input transaction
  localparam int unsigned CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_SEARCH = 3'd2,
    CMD_POP    = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_SHIFT = 6'b000100,
    ST_PUT   = 6'b001000,
    ST_POP   = 6'b010000,
    ST_RESP  = 6'b100000
  } state_e;

  // Result of the shared comparator
  typedef struct packed {
    logic eq;
    logic lt;
  } cmp_res_t;

endpackage

// ===== rtl/core/bsl_cmp.sv =====
module bsl_cmp import bsl_pkg::*; #(
  parameter int unsigned WIDTH = 32
) (
  input  logic signed [WIDTH-1:0] a_i,
  input  logic signed [WIDTH-1:0] b_i,
  output cmp_res_t                res_o
);

  // Signed magnitude compare and equality, shared by search and insert
  assign res_o.eq = (a_i == b_i);
  assign res_o.lt = (a_i < b_i);

endmodule

// ===== rtl/core/bsl_ram.sv =====
module bsl_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // One registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bounded_sorted_list.sv =====
// Channel | Direction | Handshake                | Payload
// input   | in        | in_valid_i / in_stall_o  | command_i, value_i
// output  | out       | out_valid_o / out_stall_i| result_value_o, found_o, was_empty_o,
//         |           |                          | dropped_full_o, entry_count_o
//
// One transaction at a time; the list sits in a ring buffer in a RAM with one write
// port and one registered read port. Append, clear and unknown commands go straight
// to the response; remove head reads the head entry first. Search and insert walk the
// RAM read port one entry per cycle through the scan and, for insert, the shift.
// Reset empties the list; RAM contents are not cleared.
// A stalled output holds its result; the block can take the next input meanwhile,
// and waits before its own result only while the previous one is still held.
module bounded_sorted_list import bsl_pkg::*; #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [CMD_W-1:0]                 command_i,
  input  logic signed [DATA_WIDTH-1:0]     value_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [DATA_WIDTH-1:0]     result_value_o,
  output logic                             found_o,
  output logic                             was_empty_o,
  output logic                             dropped_full_o,
  output logic [$clog2(CAPACITY+1)-1:0]    entry_count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CapWide = (AW+1)'(CAPACITY);
  localparam logic [AW-1:0] LastPos = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CapCnt  = CW'(CAPACITY);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] scan_i_q, scan_i_d;
  logic [CW-1:0] sh_j_q, sh_j_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          pend_q, pend_d;
  logic          out_valid_q, out_valid_d;

  cmd_e                  cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0]         rd_phys_q, rd_phys_d;
  logic [DATA_WIDTH-1:0] pnd_value_q, pnd_value_d;
  logic                  pnd_found_q, pnd_found_d;
  logic                  pnd_empty_q, pnd_empty_d;
  logic                  pnd_drop_q, pnd_drop_d;

  logic [DATA_WIDTH-1:0] out_value_q;
  logic                  out_found_q, out_empty_q, out_drop_q;
  logic [CW-1:0]         out_count_q;
  logic                  out_load;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic [CW-1:0] idx;
  logic [AW:0]   phys_sum;
  logic [AW-1:0] phys;
  logic [AW-1:0] rd_phys_inc, head_inc;
  logic          full, hit;
  cmp_res_t      cmp;

  // Logical position to ring address: one add and one conditional subtract
  assign phys_sum = {1'b0, head_q} + {1'b0, idx[AW-1:0]};
  assign phys     = (phys_sum >= CapWide) ? AW'(phys_sum - CapWide) : phys_sum[AW-1:0];

  assign rd_phys_inc = (rd_phys_q == LastPos) ? '0 : rd_phys_q + AW'(1);
  assign head_inc    = (head_q == LastPos) ? '0 : head_q + AW'(1);
  assign full        = (count_q == CapCnt);

  bsl_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bsl_cmp #(
    .WIDTH (DATA_WIDTH)
  ) u_cmp (
    .a_i   (mem_rdata),
    .b_i   (val_q),
    .res_o (cmp)
  );

  // Scan stops on an equal entry (search) or the first entry not below the value (insert)
  assign hit = pend_q && ((cmd_q == CMD_SEARCH) ? cmp.eq : !cmp.lt);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    head_d      = head_q;
    scan_i_d    = scan_i_q;
    sh_j_d      = sh_j_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    cmd_d       = cmd_q;
    val_d       = val_q;
    rd_phys_d   = rd_phys_q;
    pnd_value_d = pnd_value_q;
    pnd_found_d = pnd_found_q;
    pnd_empty_d = pnd_empty_q;
    pnd_drop_d  = pnd_drop_q;
    out_load    = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    idx         = count_q;
    mem_raddr   = phys;
    mem_waddr   = phys;
    mem_wdata   = val_q;

    unique case (state_q)
      ST_IDLE: begin
        mem_raddr = head_q;
        mem_wdata = value_i;
        if (in_valid_i) begin
          cmd_d       = cmd_e'(command_i);
          val_d       = value_i;
          pnd_value_d = '0;
          pnd_found_d = 1'b0;
          pnd_empty_d = 1'b0;
          pnd_drop_d  = 1'b0;
          scan_i_d    = '0;
          pend_d      = 1'b0;
          state_d     = ST_RESP;
          unique case (cmd_e'(command_i))
            CMD_APPEND: begin
              if (full) begin
                pnd_drop_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            CMD_INSERT: begin
              if (full) begin
                pnd_drop_d = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            CMD_SEARCH: begin
              state_d = ST_SCAN;
            end
            CMD_POP: begin
              if (count_q == '0) begin
                pnd_empty_d = 1'b1;
                pnd_value_d = '1;
              end else begin
                mem_re    = 1'b1;
                rd_phys_d = head_q;
                state_d   = ST_POP;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
              head_d  = '0;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        idx = scan_i_q;
        if (hit || (scan_i_q == count_q)) begin
          pend_d = 1'b0;
          pos_d  = hit ? scan_i_q - CW'(1) : count_q;
          sh_j_d = count_q;
          if (cmd_q == CMD_SEARCH) begin
            pnd_found_d = hit;
            state_d     = ST_RESP;
          end else begin
            state_d = ST_SHIFT;
          end
        end else begin
          mem_re    = 1'b1;
          rd_phys_d = phys;
          scan_i_d  = scan_i_q + CW'(1);
          pend_d    = 1'b1;
        end
      end

      // Move the tail up one place, highest entry first
      ST_SHIFT: begin
        idx       = sh_j_q - CW'(1);
        mem_waddr = rd_phys_inc;
        mem_wdata = mem_rdata;
        mem_we    = pend_q;
        if (sh_j_q > pos_q) begin
          mem_re    = 1'b1;
          rd_phys_d = phys;
          sh_j_d    = sh_j_q - CW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = ST_PUT;
          end
        end
      end

      ST_PUT: begin
        idx     = pos_q;
        mem_we  = 1'b1;
        count_d = count_q + CW'(1);
        state_d = ST_RESP;
      end

      ST_POP: begin
        pnd_value_d = mem_rdata;
        head_d      = head_inc;
        count_d     = count_q - CW'(1);
        state_d     = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the transaction is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      head_q      <= '0;
      scan_i_q    <= '0;
      sh_j_q      <= '0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      head_q      <= head_d;
      scan_i_q    <= scan_i_d;
      sh_j_q      <= sh_j_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    val_q       <= val_d;
    rd_phys_q   <= rd_phys_d;
    pnd_value_q <= pnd_value_d;
    pnd_found_q <= pnd_found_d;
    pnd_empty_q <= pnd_empty_d;
    pnd_drop_q  <= pnd_drop_d;
    if (out_load) begin
      out_value_q <= pnd_value_q;
      out_found_q <= pnd_found_q;
      out_empty_q <= pnd_empty_q;
      out_drop_q  <= pnd_drop_q;
      out_count_q <= count_q;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign found_o        = out_found_q;
  assign was_empty_o    = out_empty_q;
  assign dropped_full_o = out_drop_q;
  assign entry_count_o  = out_count_q;

endmodule
